// ===== rtl/core/css_color_string_parser_assert.svh =====
`ifndef CSS_COLOR_STRING_PARSER_ASSERT_SVH
`define CSS_COLOR_STRING_PARSER_ASSERT_SVH

// plain property checked on every clock edge outside reset
`define CCSP_ASSERT(lbl, clk, rstn, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);

// same-cycle implication
`define CCSP_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define CCSP_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/core/ccsp_pkg.sv =====
package ccsp_pkg;

	localparam int TABLE_SIZE       = 147;
	localparam int BASIC_COUNT      = 17;
	localparam int NAME_COUNT_DEF   = 147;
	localparam int MAX_NAME_LEN_DEF = 20;
	localparam int NAME_BYTES       = 20;
	localparam int NAME_BITS        = 8 * NAME_BYTES;
	localparam int POS_W            = 5;
	localparam int STATE_BANKS      = 2;

	localparam logic [POS_W-1:0] POS_MAX      = 5'd31;
	localparam logic [2:0]       HEX_MAX_DIGS = 3'd7;
	localparam logic [2:0]       HEX_SHORT    = 3'd3;
	localparam logic [2:0]       HEX_LONG     = 3'd6;
	localparam logic [7:0]       CHAR_HASH    = 8'h23;

	typedef enum logic [1:0] {
		MODE_START = 2'd0,
		MODE_HEX   = 2'd1,
		MODE_NAME  = 2'd2,
		MODE_DONE  = 2'd3
	} mode_t;

	typedef struct packed {
		logic        ok;
		logic [23:0] rgb;
		logic [4:0]  len;
	} res_t;

	typedef struct packed {
		mode_t           mode;
		logic [POS_W-1:0] pos;
		logic [2:0]      cnt;
		logic [23:0]     nib;
		res_t            dec;
	} ctx_t;

	localparam ctx_t CTX_RESET = '{mode: MODE_START, pos: '0, cnt: '0, nib: '0, dec: '0};

	// name lookup results handed from the match array to the step logic
	typedef struct packed {
		logic        term_hit;
		logic [23:0] term_rgb;
		logic        end_hit;
		logic [23:0] end_rgb;
	} nm_res_t;

	localparam logic [NAME_BITS-1:0] NAME_TXT [TABLE_SIZE] = '{
		"aqua","black","blue","fuchsia","gray","green","lime","maroon",
		"navy","olive","orange","purple","red","silver","teal","white",
		"yellow",
		"aliceblue","antiquewhite","aquamarine","azure","beige","bisque",
		"blanchedalmond","blueviolet","brown","burlywood","cadetblue","chartreuse",
		"chocolate","coral","cornflowerblue","cornsilk","crimson","cyan",
		"darkblue","darkcyan","darkgoldenrod","darkgray","darkgreen","darkgrey",
		"darkkhaki","darkmagenta","darkolivegreen","darkorange","darkorchid","darkred",
		"darksalmon","darkseagreen","darkslateblue","darkslategray","darkslategrey",
		"darkturquoise","darkviolet","deeppink","deepskyblue","dimgray","dimgrey",
		"dodgerblue","firebrick","floralwhite","forestgreen","gainsboro","ghostwhite",
		"gold","goldenrod","greenyellow","grey","honeydew","hotpink",
		"indianred","indigo","ivory","khaki","lavender","lavenderblush",
		"lawngreen","lemonchiffon","lightblue","lightcoral","lightcyan",
		"lightgoldenrodyellow","lightgray","lightgreen","lightgrey","lightpink",
		"lightsalmon","lightseagreen","lightskyblue","lightslategray",
		"lightslategrey","lightsteelblue","lightyellow","limegreen","linen",
		"magenta","mediumaquamarine","mediumblue","mediumorchid","mediumpurple",
		"mediumseagreen","mediumslateblue","mediumspringgreen","mediumturquoise",
		"mediumvioletred","midnightblue","mintcream","mistyrose","moccasin",
		"navajowhite","oldlace","olivedrab","orangered","orchid","palegoldenrod",
		"palegreen","paleturquoise","palevioletred","papayawhip","peachpuff",
		"peru","pink","plum","powderblue","rosybrown","royalblue",
		"saddlebrown","salmon","sandybrown","seagreen","seashell","sienna",
		"skyblue","slateblue","slategray","slategrey","snow","springgreen",
		"steelblue","tan","thistle","tomato","turquoise","violet",
		"wheat","whitesmoke","yellowgreen"
	};

	localparam logic [23:0] NAME_RGB [TABLE_SIZE] = '{
		24'h00ffff,24'h000000,24'h0000ff,24'hff00ff,24'h808080,24'h008000,
		24'h00ff00,24'h800000,24'h000080,24'h808000,24'hffa500,24'h800080,
		24'hff0000,24'hc0c0c0,24'h008080,24'hffffff,24'hffff00,
		24'hf0f8ff,24'hfaebd7,24'h7fffd4,24'hf0ffff,24'hf5f5dc,24'hffe4c4,
		24'hffebcd,24'h8a2be2,24'ha52a2a,24'hdeb887,24'h5f9ea0,24'h7fff00,
		24'hd2691e,24'hff7f50,24'h6495ed,24'hfff8dc,24'hdc143c,24'h00ffff,
		24'h00008b,24'h008b8b,24'hb8860b,24'ha9a9a9,24'h006400,24'ha9a9a9,
		24'hbdb76b,24'h8b008b,24'h556b2f,24'hff8c00,24'h9932cc,24'h8b0000,
		24'he9967a,24'h8fbc8f,24'h483d8b,24'h2f4f4f,24'h2f4f4f,
		24'h00ced1,24'h9400d3,24'hff1493,24'h00bfff,24'h696969,24'h696969,
		24'h1e90ff,24'hb22222,24'hfffaf0,24'h228b22,24'hdcdcdc,24'hf8f8ff,
		24'hffd700,24'hdaa520,24'hadff2f,24'h808080,24'hf0fff0,24'hff69b4,
		24'hcd5c5c,24'h4b0082,24'hfffff0,24'hf0e68c,24'he6e6fa,24'hfff0f5,
		24'h7cfc00,24'hfffacd,24'hadd8e6,24'hf08080,24'he0ffff,
		24'hfafad2,24'hd3d3d3,24'h90ee90,24'hd3d3d3,24'hffb6c1,
		24'hffa07a,24'h20b2aa,24'h87cefa,24'h778899,
		24'h778899,24'hb0c4de,24'hffffe0,24'h32cd32,24'hfaf0e6,
		24'hff00ff,24'h66cdaa,24'h0000cd,24'hba55d3,24'h9370db,
		24'h3cb371,24'h7b68ee,24'h00fa9a,24'h48d1cc,
		24'hc71585,24'h191970,24'hf5fffa,24'hffe4e1,24'hffe4b5,
		24'hffdead,24'hfdf5e6,24'h6b8e23,24'hff4500,24'hda70d6,24'heee8aa,
		24'h98fb98,24'hafeeee,24'hdb7093,24'hffefd5,24'hffdab9,
		24'hcd853f,24'hffc0cb,24'hdda0dd,24'hb0e0e6,24'hbc8f8f,24'h4169e1,
		24'h8b4513,24'hfa8072,24'hf4a460,24'h2e8b57,24'hfff5ee,24'ha0522d,
		24'h87ceeb,24'h6a5acd,24'h708090,24'h708090,24'hfffafa,24'h00ff7f,
		24'h4682b4,24'hd2b48c,24'hd8bfd8,24'hff6347,24'h40e0d0,24'hee82ee,
		24'hf5deb3,24'hf5f5f5,24'h9acd32
	};

	function automatic int name_len(input logic [NAME_BITS-1:0] t);
		int n;
		n = 0;
		for (int k = 0; k < NAME_BYTES; k++) begin
			if (t[8*k +: 8] != 8'h00) n++;
		end
		return n;
	endfunction

	// t holds the name left-aligned, first char in the top byte
	function automatic logic [7:0] char_at(input logic [NAME_BITS-1:0] t,
			input logic [POS_W-1:0] p);
		logic [7:0] c;
		c = '0;
		for (int k = 0; k < NAME_BYTES; k++) begin
			if (p == POS_W'(k)) c = t[NAME_BITS-1-8*k -: 8];
		end
		return c;
	endfunction

	function automatic logic [7:0] lower_char(input logic [7:0] b);
		return (b >= "A" && b <= "Z") ? b + 8'd32 : b;
	endfunction

	function automatic logic is_alnum(input logic [7:0] b);
		logic [7:0] l;
		l = lower_char(b);
		return (b >= "0" && b <= "9") || (l >= "a" && l <= "z");
	endfunction

	function automatic res_t settle_hex(input logic [2:0] cnt, input logic [23:0] n);
		res_t r;
		r = '0;
		case (cnt)
			HEX_SHORT: begin
				r.ok  = 1'b1;
				r.rgb = {n[11:8], n[11:8], n[7:4], n[7:4], n[3:0], n[3:0]};
				r.len = 5'(HEX_SHORT);
			end
			HEX_LONG: begin
				r.ok  = 1'b1;
				r.rgb = n;
				r.len = 5'(HEX_LONG);
			end
			default: r = '0;
		endcase
		return r;
	endfunction

endpackage

// ===== rtl/core/css_color_string_parser.sv =====
// colour string parser: takes a css colour string one byte per beat and
// returns one result beat on the byte marked last_char
// input channel: in_valid / in_stall with char_byte, last_char
// output channel: out_valid / out_stall with valid_res, rgb_color, used_length
// config channel: cfg_valid / cfg_ready with extended_names (0 = 17 basic
// names, 1 = full table); write it only while no string is in flight
// strings starting with '#' take 3 or 6 hex digits, anything else is looked
// up in the name table; a failure gives valid_res = 0 with zero fields
// throughput: one byte per cycle while no last byte is held by a stalled
// result; strings may follow back to back, and the result of a string is
// registered into the output register as its last byte leaves stage 1
// the per-string context lives in a two-entry ram, one entry per string in
// flight; each byte reads and updates it, every byte but the last writes it
// back, and a byte that follows straight on takes the write-back value from
// a forwarding register; reset clears the control state and marks both ram
// entries empty, so no clearing pass is needed; extended_names resets to 0
// when out_stall holds a result, a last byte waiting behind it holds in_stall
// high; other bytes keep flowing
module css_color_string_parser import ccsp_pkg::*; #(
	parameter int NAME_COUNT   = NAME_COUNT_DEF,
	parameter int MAX_NAME_LEN = MAX_NAME_LEN_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  char_byte,
	input  logic        last_char,
	output logic        out_valid,
	input  logic        out_stall,
	output logic        valid_res,
	output logic [23:0] rgb_color,
	output logic [4:0]  used_length,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic        extended_names
);

	localparam int WORD_W = NAME_COUNT + $bits(ctx_t);

	// config register
	logic ext_q;

	// bank select on the input side and per-bank occupancy
	logic                   bank_q;
	logic [STATE_BANKS-1:0] bank_vld_q;

	// stage 1: byte being processed against its context
	logic              v_s1;
	logic [7:0]        byte_s1;
	logic              last_s1;
	logic              bank_s1;
	logic              rdok_s1;
	logic              fwd_s1;
	logic [WORD_W-1:0] fwdw_s1;

	logic              in_acc;
	logic              s1_blk;
	logic              s1_fire;
	logic [WORD_W-1:0] rdata;
	logic [WORD_W-1:0] cur_w;
	logic [WORD_W-1:0] nxt_w;

	logic [NAME_COUNT-1:0] cur_alive, nxt_alive, nm_alive;
	ctx_t                  cur_ctx, nxt_ctx;
	nm_res_t               nm;
	res_t                  out_res;

	logic       dig_ok;
	logic [3:0] dig_v;
	logic [7:0] lc;
	logic [2:0] cnt_inc;
	logic [23:0] nib_sh;

	assign cfg_ready = 1'b1;

	assign in_acc  = in_valid && !in_stall;
	// a last byte can only leave when the output register is free
	assign s1_blk  = v_s1 && last_s1 && out_valid && out_stall;
	assign s1_fire = v_s1 && !s1_blk;
	assign in_stall = s1_blk;

	ccsp_ram #(
		.WIDTH (WORD_W),
		.DEPTH (STATE_BANKS)
	) u_ctx_ram (
		.clk   (clk),
		.we    (s1_fire && !last_s1),
		.waddr (bank_s1),
		.wdata (nxt_w),
		.re    (in_acc),
		.raddr (bank_q),
		.rdata (rdata)
	);

	// context source: forwarded write-back, stored entry, or fresh string
	always_comb begin
		if (fwd_s1) cur_w = fwdw_s1;
		else if (rdok_s1) cur_w = rdata;
		else cur_w = {{NAME_COUNT{1'b1}}, CTX_RESET};
	end

	assign cur_alive = cur_w[WORD_W-1 -: NAME_COUNT];
	assign cur_ctx   = ctx_t'(cur_w[$bits(ctx_t)-1:0]);

	ccsp_name_match #(
		.NAME_COUNT   (NAME_COUNT),
		.MAX_NAME_LEN (MAX_NAME_LEN)
	) u_match (
		.char_byte (byte_s1),
		.pos       (cur_ctx.pos),
		.ext       (ext_q),
		.alive     (cur_alive),
		.alive_nxt (nm_alive),
		.res       (nm)
	);

	// hex digit decode
	always_comb begin
		lc = byte_s1 | 8'h20;
		dig_ok = 1'b0;
		dig_v  = '0;
		if (byte_s1 >= "0" && byte_s1 <= "9") begin
			dig_ok = 1'b1;
			dig_v  = 4'(byte_s1 - "0");
		end else if (lc >= "a" && lc <= "f") begin
			dig_ok = 1'b1;
			dig_v  = 4'(lc - "a" + 8'd10);
		end
	end

	assign cnt_inc = cur_ctx.cnt + 3'd1;
	assign nib_sh  = {cur_ctx.nib[19:0], dig_v};

	// one byte of the parse: read-modify of the string context
	always_comb begin
		logic name_go;
		nxt_ctx   = cur_ctx;
		nxt_alive = cur_alive;
		name_go   = 1'b0;
		case (cur_ctx.mode)
			MODE_START: begin
				if (byte_s1 == CHAR_HASH) nxt_ctx.mode = MODE_HEX;
				else begin
					nxt_ctx.mode = MODE_NAME;
					name_go = 1'b1;
				end
			end
			MODE_HEX: begin
				if (!dig_ok) begin
					nxt_ctx.dec  = settle_hex(cur_ctx.cnt, cur_ctx.nib);
					nxt_ctx.mode = MODE_DONE;
				end else begin
					nxt_ctx.nib = nib_sh;
					nxt_ctx.cnt = cnt_inc;
					// too many digits: fails, rest of the string ignored
					if (cnt_inc >= HEX_MAX_DIGS) begin
						nxt_ctx.dec  = settle_hex(cnt_inc, nib_sh);
						nxt_ctx.mode = MODE_DONE;
					end
				end
			end
			MODE_NAME: name_go = 1'b1;
			MODE_DONE: ;
			default: ;
		endcase

		if (name_go) begin
			if (nm.term_hit) begin
				nxt_ctx.dec  = '{ok: 1'b1, rgb: nm.term_rgb, len: cur_ctx.pos};
				nxt_ctx.mode = MODE_DONE;
			end else begin
				nxt_alive = nm_alive;
			end
		end

		if (cur_ctx.pos != POS_MAX) nxt_ctx.pos = cur_ctx.pos + 1'b1;

		// end of string closes whatever is still open
		out_res = nxt_ctx.dec;
		if (nxt_ctx.mode == MODE_HEX) out_res = settle_hex(nxt_ctx.cnt, nxt_ctx.nib);
		else if (nxt_ctx.mode == MODE_NAME) begin
			out_res = nm.end_hit ? '{ok: 1'b1, rgb: nm.end_rgb, len: nxt_ctx.pos} : '0;
		end
	end

	assign nxt_w = {nxt_alive, nxt_ctx};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ext_q <= 1'b0;
		end else if (cfg_valid && cfg_ready) begin
			ext_q <= extended_names;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bank_q     <= 1'b0;
			bank_vld_q <= '0;
			v_s1       <= 1'b0;
			fwd_s1     <= 1'b0;
			rdok_s1    <= 1'b0;
		end else begin
			if (in_acc && last_char) bank_q <= !bank_q;
			// an entry is live from its first write-back until its last byte
			if (s1_fire) bank_vld_q[bank_s1] <= !last_s1;
			if (in_acc) begin
				v_s1    <= 1'b1;
				rdok_s1 <= bank_vld_q[bank_q];
				fwd_s1  <= s1_fire && !last_s1 && (bank_s1 == bank_q);
			end else if (s1_fire) begin
				v_s1 <= 1'b0;
			end
		end
	end

	// stage payload
	always_ff @(posedge clk) begin
		if (in_acc) begin
			byte_s1 <= char_byte;
			last_s1 <= last_char;
			bank_s1 <= bank_q;
			fwdw_s1 <= nxt_w;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (s1_fire && last_s1) begin
			out_valid <= 1'b1;
		end else if (!out_stall) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_fire && last_s1) begin
			valid_res   <= out_res.ok;
			rgb_color   <= out_res.rgb;
			used_length <= out_res.len;
		end
	end

endmodule

// ===== rtl/core/ccsp_ram.sv =====
module ccsp_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) mem[waddr] <= wdata;
		if (re) rdata <= mem[raddr];
	end

endmodule

// ===== rtl/core/ccsp_name_match.sv =====
module ccsp_name_match import ccsp_pkg::*; #(
	parameter int NAME_COUNT   = NAME_COUNT_DEF,
	parameter int MAX_NAME_LEN = MAX_NAME_LEN_DEF
) (
	input  logic [7:0]            char_byte,
	input  logic [POS_W-1:0]      pos,
	input  logic                  ext,
	input  logic [NAME_COUNT-1:0] alive,
	output logic [NAME_COUNT-1:0] alive_nxt,
	output nm_res_t               res
);

	logic [7:0]            lb;
	logic                  alnum;
	logic [NAME_COUNT-1:0] term;
	logic [NAME_COUNT-1:0] endm;

	assign lb    = lower_char(char_byte);
	assign alnum = is_alnum(char_byte);

	for (genvar i = 0; i < NAME_COUNT; i++) begin : g_ent
		localparam int L = name_len(NAME_TXT[i]);
		localparam logic [POS_W-1:0] LEN = POS_W'(L);
		localparam logic [NAME_BITS-1:0] T = NAME_TXT[i] << (8 * (NAME_BYTES - L));
		localparam bit LEN_OK = (L <= MAX_NAME_LEN);
		logic act, cont;

		if (i < BASIC_COUNT) begin : g_basic
			assign act = 1'b1;
		end else begin : g_ext
			assign act = ext;
		end

		assign cont = alive[i] && LEN_OK && (pos < LEN) && (lb == char_at(T, pos));
		assign term[i] = act && alive[i] && LEN_OK && (pos == LEN) && !alnum;
		// this byte completes the name: counts if the string ends here
		assign endm[i] = act && cont && (POS_W'(pos + 1'b1) == LEN);
		assign alive_nxt[i] = act ? cont : alive[i];
	end

	// names are distinct, so at most one entry hits at a time
	always_comb begin
		res = '0;
		for (int i = 0; i < NAME_COUNT; i++) begin
			if (term[i]) res.term_rgb = res.term_rgb | NAME_RGB[i];
			if (endm[i]) res.end_rgb  = res.end_rgb  | NAME_RGB[i];
		end
		res.term_hit = |term;
		res.end_hit  = |endm;
	end

endmodule

// ===== rtl/core/ccsp_checker.sv =====
`include "css_color_string_parser_assert.svh"

module ccsp_port_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_stall,
	input logic        last_char,
	input logic        out_valid,
	input logic        out_stall,
	input logic        valid_res,
	input logic [23:0] rgb_color,
	input logic [4:0]  used_length
);

	`CCSP_ASSERT_NXT(a_out_hold, clk, arst_n, out_valid && out_stall, out_valid,
		"stalled result dropped")

	`CCSP_ASSERT_IMP(a_fail_zero, clk, arst_n, out_valid && !valid_res,
		rgb_color == 24'd0 && used_length == 5'd0, "failed result not zero")

	`CCSP_ASSERT_IMP(a_ok_len, clk, arst_n, out_valid && valid_res,
		used_length >= 5'd3 && used_length <= 5'd20, "bad used length")

	// a fresh result must trace back to an accepted last byte
	`CCSP_ASSERT_IMP(a_rose_src, clk, arst_n, $rose(out_valid),
		$past(in_valid && !in_stall && last_char, 2), "result without last byte")

endmodule

bind css_color_string_parser ccsp_port_checker u_ccsp_checker (.*);
